### rtl/edge_binned_histogram_unit_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the edge-binned histogram unit
// Concurrent check wrappers; they expand to nothing when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef EDGE_BINNED_HISTOGRAM_UNIT_DEFINES_SVH
`define EDGE_BINNED_HISTOGRAM_UNIT_DEFINES_SVH

`ifndef SYNTH
// Check that an expression holds at every clock edge
`define EBH_ASSERT_ALW(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
// Check that a condition implies a consequence in the same cycle
`define EBH_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Check that a condition implies a consequence in the next cycle
`define EBH_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define EBH_ASSERT_ALW(label, expr, msg)
`define EBH_ASSERT_IMP(label, ante, cons, msg)
`define EBH_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

### rtl/ebh_pkg.sv
// ---------------------------------------------------------------------------
// ebh_pkg
// Types, constants and helpers shared by the edge-binned histogram files.
// ---------------------------------------------------------------------------
package ebh_pkg;

  localparam int MAX_EDGES     = 7;
  localparam int NUM_BINS      = MAX_EDGES + 1;
  localparam int PIXEL_BITS    = 8;
  localparam int COUNT_BITS    = 32;
  localparam int OUT_BITS      = 32;
  localparam int BIN_IDX_BITS  = 3;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 8;

  typedef logic [PIXEL_BITS-1:0]    pixel_t;
  typedef logic [COUNT_BITS-1:0]    cnt_t;
  typedef logic [OUT_BITS-1:0]      out_cnt_t;
  typedef logic [BIN_IDX_BITS-1:0]  bin_idx_t;
  typedef logic [CFG_IDX_BITS-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_BITS-1:0] cfg_data_t;

  // Register indexes of the configuration port
  localparam cfg_idx_t CFG_EDGE_COUNT = cfg_idx_t'(0);
  localparam cfg_idx_t CFG_EDGE_0     = cfg_idx_t'(1);

  localparam cnt_t COUNT_MAX = '1;
  localparam cnt_t COUNT_ONE = cnt_t'(1);

  // Word handed from one cell to the next
  typedef struct packed {
    logic   valid;
    logic   tok;
    logic   taken;
    pixel_t pixel;
  } link_t;

  // Result word offered by a cell during readout
  typedef struct packed {
    logic     valid;
    logic     last;
    bin_idx_t index;
    out_cnt_t count;
  } emit_t;

  // Clamp a counter into the result field
  function automatic out_cnt_t sat_count(input cnt_t cnt);
    logic [COUNT_BITS+OUT_BITS-1:0] wide;
    wide = {{OUT_BITS{1'b0}}, cnt};
    if ((wide >> OUT_BITS) != '0) begin
      return '1;
    end
    return OUT_BITS'(cnt);
  endfunction

endpackage

### rtl/ebh_pix_if.sv
// ---------------------------------------------------------------------------
// ebh_pix_if
// Pixel channel: one pixel word with its end-of-region flag.
// ---------------------------------------------------------------------------
interface ebh_pix_if;
  logic            valid;
  logic            ready;
  ebh_pkg::pixel_t pixel;
  logic            last_pixel;

  modport source (output valid, output pixel, output last_pixel, input ready);
  modport sink (input valid, input pixel, input last_pixel, output ready);
endinterface

### rtl/ebh_bin_if.sv
// ---------------------------------------------------------------------------
// ebh_bin_if
// Result channel: one bin count word per handshake.
// ---------------------------------------------------------------------------
interface ebh_bin_if;
  logic              valid;
  logic              ready;
  ebh_pkg::bin_idx_t bin_index;
  ebh_pkg::out_cnt_t bin_count;
  logic              last_bin;

  modport source (output valid, output bin_index, output bin_count, output last_bin,
                  input ready);
  modport sink (input valid, input bin_index, input bin_count, input last_bin,
                output ready);
endinterface

### rtl/ebh_cfg_if.sv
// ---------------------------------------------------------------------------
// ebh_cfg_if
// Configuration write channel: register index and write data.
// ---------------------------------------------------------------------------
interface ebh_cfg_if;
  logic               valid;
  logic               ready;
  ebh_pkg::cfg_idx_t  reg_index;
  ebh_pkg::cfg_data_t wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

### rtl/ebh_cell.sv
// ---------------------------------------------------------------------------
// ebh_cell
// One histogram bin: edge compare, saturating counter, readout and clear.
// ---------------------------------------------------------------------------
module ebh_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  ebh_pkg::bin_idx_t cell_idx,
  input  ebh_pkg::bin_idx_t n_active,
  input  ebh_pkg::pixel_t   edge_val,
  input  ebh_pkg::link_t    link_in,
  output ebh_pkg::link_t    link_out,
  output ebh_pkg::emit_t    emit
);

  ebh_pkg::cnt_t  count;
  ebh_pkg::cnt_t  count_next;
  ebh_pkg::cnt_t  count_inc;
  ebh_pkg::link_t link_next;
  logic           hit;

  // Claim the pixel if no lower bin took it
  always_comb begin
    hit = link_in.valid && !link_in.taken &&
          ((cell_idx == n_active) ||
           ((cell_idx < n_active) && (link_in.pixel <= edge_val)));
    count_inc = (hit && (count != ebh_pkg::COUNT_MAX)) ? count + ebh_pkg::COUNT_ONE : count;
  end

  // Count, or report and clear when the readout token passes
  always_comb begin
    count_next = count;
    if (adv && link_in.valid) begin
      count_next = link_in.tok ? '0 : count_inc;
    end
    emit.valid = link_in.valid && link_in.tok && (cell_idx <= n_active);
    emit.last  = (cell_idx == n_active);
    emit.index = cell_idx;
    emit.count = ebh_pkg::sat_count(count_inc);
  end

  // Hand the word to the next cell
  always_comb begin
    link_next       = link_in;
    link_next.taken = link_in.taken || hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      link_out <= '0;
    end else begin
      count <= count_next;
      if (adv) begin
        link_out <= link_next;
      end
    end
  end

endmodule

### rtl/edge_binned_histogram_unit.sv
// Readout: bin results leave in bin order as the token walks the cell chain.
// Throughput: one pixel per cycle through the eight-cell bin chain; a pixel that
// ends a region waits until the previous readout token has left the chain.
// The chain halts while the output word is held.
// Reset: counters, edges and edge count are cleared directly by reset, no sweep.
// ---------------------------------------------------------------------------
// edge_binned_histogram_unit
// Histogram of a pixel stream into bins bounded by programmable upper edges.
// ---------------------------------------------------------------------------
`include "edge_binned_histogram_unit_defines.svh"

module edge_binned_histogram_unit (
  input logic   clk,
  input logic   rst,
  ebh_pix_if.sink   pix,
  ebh_bin_if.source readout,
  ebh_cfg_if.sink   cfg
);

  ebh_pkg::bin_idx_t edge_count;
  ebh_pkg::pixel_t   edges [ebh_pkg::MAX_EDGES];
  ebh_pkg::bin_idx_t n_active;
  ebh_pkg::cfg_idx_t edge_sel;

  ebh_pkg::link_t    link [ebh_pkg::NUM_BINS+1];
  ebh_pkg::emit_t    emit [ebh_pkg::NUM_BINS];
  ebh_pkg::pixel_t   edge_in [ebh_pkg::NUM_BINS];
  logic [ebh_pkg::NUM_BINS-1:0] emit_vec;
  logic [ebh_pkg::NUM_BINS-1:0] tok_vec;

  logic              adv;
  logic              busy;
  ebh_pkg::emit_t    emit_sel;
  logic              out_valid;
  ebh_pkg::bin_idx_t out_index;
  ebh_pkg::out_cnt_t out_count;
  logic              out_last;

  // Configuration writes
  assign cfg.ready = 1'b1;
  assign edge_sel  = cfg.reg_index - ebh_pkg::CFG_EDGE_0;

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_count <= '0;
      for (int i = 0; i < ebh_pkg::MAX_EDGES; i++) begin
        edges[i] <= '0;
      end
    end else if (cfg.valid) begin
      if (cfg.reg_index == ebh_pkg::CFG_EDGE_COUNT) begin
        edge_count <= ebh_pkg::BIN_IDX_BITS'(cfg.wdata);
      end else if ((cfg.reg_index >= ebh_pkg::CFG_EDGE_0) &&
                   (int'(edge_sel) < ebh_pkg::MAX_EDGES)) begin
        edges[edge_sel] <= ebh_pkg::PIXEL_BITS'(cfg.wdata);
      end
    end
  end

  assign n_active = (int'(edge_count) > ebh_pkg::MAX_EDGES) ?
                    ebh_pkg::bin_idx_t'(ebh_pkg::MAX_EDGES) : edge_count;

  // Advance the chain whenever the output slot is free or draining
  assign adv = !out_valid || readout.ready;

  always_comb begin
    for (int k = 0; k < ebh_pkg::NUM_BINS; k++) begin
      tok_vec[k]  = link[k+1].valid && link[k+1].tok;
      emit_vec[k] = emit[k].valid;
    end
  end
  assign busy = |tok_vec;

  // Hold a region end while a readout is still in the chain
  assign pix.ready = adv && (!pix.last_pixel || !busy);

  // Chain entry: valid, token, taken, pixel
  assign link[0] = {pix.valid && pix.ready, pix.last_pixel, 1'b0, pix.pixel};

  // Bin chain
  for (genvar k = 0; k < ebh_pkg::NUM_BINS; k++) begin : g_cell
    if (k < ebh_pkg::MAX_EDGES) begin : g_edge
      assign edge_in[k] = edges[k];
    end else begin : g_over
      assign edge_in[k] = '0;
    end

    ebh_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .cell_idx (ebh_pkg::bin_idx_t'(k)),
      .n_active (n_active),
      .edge_val (edge_in[k]),
      .link_in  (link[k]),
      .link_out (link[k+1]),
      .emit     (emit[k])
    );
  end

  // Pick the one cell reporting this cycle
  always_comb begin
    emit_sel = '0;
    for (int k = 0; k < ebh_pkg::NUM_BINS; k++) begin
      if (emit[k].valid) begin
        emit_sel = emit[k];
      end
    end
  end

  // Output word register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= emit_sel.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_index <= emit_sel.index;
      out_count <= emit_sel.count;
      out_last  <= emit_sel.last;
    end
  end

  assign readout.valid     = out_valid;
  assign readout.bin_index = out_index;
  assign readout.bin_count = out_count;
  assign readout.last_bin  = out_last;

  // Checks
  `EBH_ASSERT_ALW(a_one_emit, $onehot0(emit_vec), "two bin cells report in one cycle")
  `EBH_ASSERT_ALW(a_one_token, $onehot0(tok_vec), "more than one readout token in chain")
  `EBH_ASSERT_IMP(a_last_index, out_valid && out_last, out_index == n_active, "wrong final index")
  `EBH_ASSERT_NXT(a_tok_enter, link[0].valid && link[0].tok, tok_vec[0], "token lost at entry")

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the edge-binned histogram unit. A scoreboard keeps
// its own bin counters and edge settings, predicts each readout run when a
// region closes and compares every bin word, field by field, as it leaves.
// ---------------------------------------------------------------------------

// One predicted bin word of a readout run
typedef struct {
  ebh_pkg::bin_idx_t index;
  ebh_pkg::out_cnt_t count;
  logic              last;
} bin_word_t;

class histogram_scoreboard;
  ebh_pkg::bin_idx_t edge_total;
  ebh_pkg::pixel_t   edge_bound[ebh_pkg::MAX_EDGES];
  ebh_pkg::cnt_t     bin_tally[ebh_pkg::NUM_BINS];
  bin_word_t         readout_q[$];
  int                errors;
  int                words_checked;

  // Start from the reset state: no edges, all counters empty
  function new();
    edge_total = '0;
    foreach (edge_bound[k]) edge_bound[k] = '0;
    foreach (bin_tally[k]) bin_tally[k] = '0;
    errors = 0;
    words_checked = 0;
  endfunction

  // Apply a register write taken on the configuration port
  function void set_register(ebh_pkg::cfg_idx_t idx, ebh_pkg::cfg_data_t data);
    if (idx == ebh_pkg::CFG_EDGE_COUNT) begin
      edge_total = data[ebh_pkg::BIN_IDX_BITS-1:0];
    end else begin
      edge_bound[int'(idx) - int'(ebh_pkg::CFG_EDGE_0)] = data[ebh_pkg::PIXEL_BITS-1:0];
    end
  endfunction

  // Bin one accepted pixel; on the last pixel of a region queue the readout
  function void count_pixel(ebh_pkg::pixel_t px, logic lst);
    int used;
    int bin;
    bin_word_t w;
    used = (int'(edge_total) > ebh_pkg::MAX_EDGES) ? ebh_pkg::MAX_EDGES : int'(edge_total);
    bin = used;
    // scan downward so that the lowest matching edge wins
    for (int k = used - 1; k >= 0; k--) begin
      if (px <= edge_bound[k]) bin = k;
    end
    if (bin_tally[bin] != ebh_pkg::COUNT_MAX) bin_tally[bin] += ebh_pkg::COUNT_ONE;
    if (lst) begin
      // counter and result field have the same width, so no clamp is needed
      for (int k = 0; k <= used; k++) begin
        w.index = ebh_pkg::bin_idx_t'(k);
        w.count = ebh_pkg::out_cnt_t'(bin_tally[k]);
        w.last  = (k == used);
        readout_q.push_back(w);
      end
      foreach (bin_tally[k]) bin_tally[k] = '0;
    end
  endfunction

  // Compare one bin word leaving the block with the oldest prediction
  function void check_bin(ebh_pkg::bin_idx_t idx, ebh_pkg::out_cnt_t cnt, logic lst);
    bin_word_t want;
    if (readout_q.size() == 0) begin
      errors++;
      $display("%0t: bin word with nothing expected: index %0d count %0d last %0b",
               $time, idx, cnt, lst);
      return;
    end
    want = readout_q.pop_front();
    words_checked++;
    if (idx !== want.index) begin
      errors++;
      $display("%0t: bin_index mismatch: expected %0d, got %0d", $time, want.index, idx);
    end
    if (cnt !== want.count) begin
      errors++;
      $display("%0t: bin_count mismatch on bin %0d: expected %0d, got %0d",
               $time, want.index, want.count, cnt);
    end
    if (lst !== want.last) begin
      errors++;
      $display("%0t: last_bin mismatch on bin %0d: expected %0b, got %0b",
               $time, want.index, want.last, lst);
    end
  endfunction

  function int pending();
    return readout_q.size();
  endfunction
endclass

module testbench;
  localparam int RANDOM_PIXELS   = 500;
  localparam int SETTLE_CYCLES   = 16;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int CYCLE_LIMIT     = 200000;

  logic clk;
  logic rst;

  ebh_pix_if pix();
  ebh_bin_if readout();
  ebh_cfg_if cfg();

  histogram_scoreboard sb = new();

  bit steady_src   = 1'b0;
  bit steady_sink  = 1'b0;
  bit hold_off_req = 1'b0;
  int cycle_count  = 0;
  int pixels_sent  = 0;
  int regions      = 0;
  int settings     = 0;
  int drains       = 0;
  int hold_offs    = 0;

  edge_binned_histogram_unit DUT (
    .clk     (clk),
    .rst     (rst),
    .pix     (pix),
    .readout (readout),
    .cfg     (cfg)
  );

  // 100 MHz clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d bin words outstanding", $time, sb.pending());
      $display("** edge_binned_histogram_unit: FAILED **");
      $finish;
    end
  end

  // Offer one pixel word after a random gap and hold it until taken
  task automatic send_pixel(input ebh_pkg::pixel_t px, input logic lst);
    int gap;
    gap = steady_src ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      pix.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix.valid      <= 1'b1;
    pix.pixel      <= px;
    pix.last_pixel <= lst;
    do @(negedge clk); while (!pix.ready);
    @(posedge clk);
    sb.count_pixel(px, lst);
    pixels_sent++;
    if (lst) regions++;
  endtask

  // Drop the pixel valid and wait until every predicted word has left
  task automatic settle();
    pix.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    drains++;
  endtask

  // Write one register; valid stays high for a following write
  task automatic write_register(input ebh_pkg::cfg_idx_t idx, input ebh_pkg::cfg_data_t data);
    cfg.valid     <= 1'b1;
    cfg.reg_index <= idx;
    cfg.wdata     <= data;
    do @(negedge clk); while (!cfg.ready);
    @(posedge clk);
    sb.set_register(idx, data);
  endtask

  // Write the edge count (junk in the upper bits) and the first edge_writes edges
  task automatic program_bins(input int count, input int bound[ebh_pkg::MAX_EDGES],
                              input int edge_writes);
    write_register(ebh_pkg::CFG_EDGE_COUNT, {5'($urandom), 3'(count)});
    for (int k = 0; k < edge_writes; k++) begin
      write_register(ebh_pkg::cfg_idx_t'(int'(ebh_pkg::CFG_EDGE_0) + k),
                     ebh_pkg::cfg_data_t'(bound[k]));
    end
    cfg.valid <= 1'b0;
    settings++;
  endtask

  // Result side: random stall per word, one long hold-off on request
  initial begin : bin_sink
    int stall;
    readout.ready <= 1'b0;
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        stall = HOLD_OFF_CYCLES;
        hold_off_req = 1'b0;
        hold_offs++;
      end else begin
        stall = steady_sink ? 0 : $urandom_range(0, 9);
      end
      if (stall > 0) begin
        readout.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      readout.ready <= 1'b1;
      do @(negedge clk); while (!readout.valid);
      @(posedge clk);
    end
  end

  // Check each word in the cycle before the edge that takes it
  always @(negedge clk) begin
    if (rst === 1'b0 && readout.valid === 1'b1 && readout.ready === 1'b1) begin
      sb.check_bin(readout.bin_index, readout.bin_count, readout.last_bin);
    end
  end

  initial begin : stimulus
    int bound[ebh_pkg::MAX_EDGES];
    int walk_px[7];
    int random_pixels;
    int phase;
    int style;
    int count;
    int items;
    int region_max;
    int region_left;
    int used;
    int v;
    bit close_phase;
    logic lst;

    rst            <= 1'b1;
    pix.valid      <= 1'b0;
    pix.pixel      <= '0;
    pix.last_pixel <= 1'b0;
    cfg.valid      <= 1'b0;
    cfg.reg_index  <= ebh_pkg::CFG_EDGE_COUNT;
    cfg.wdata      <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: no edges, everything lands in the single overflow bin
    send_pixel(8'd0, 1'b0);
    send_pixel(8'd255, 1'b0);
    send_pixel(8'd128, 1'b1);
    settle();

    // All edges in use (edge count at its maximum), pixels on and just past the extremes
    bound = '{0, 40, 80, 120, 160, 200, 254};
    program_bins(7, bound, 7);
    walk_px = '{0, 1, 40, 41, 254, 255, 128};
    foreach (walk_px[i]) send_pixel(ebh_pkg::pixel_t'(walk_px[i]), i == 6);
    settle();

    // Edges out of order: bin one can never win
    bound = '{200, 100, 255, 0, 0, 0, 0};
    program_bins(3, bound, 7);
    send_pixel(8'd50, 1'b0);
    send_pixel(8'd201, 1'b0);
    send_pixel(8'd255, 1'b1);
    settle();

    // Region left open across an edge-count change; dropped bin must clear
    bound = '{100, 200, 0, 0, 0, 0, 0};
    program_bins(2, bound, 2);
    send_pixel(8'd250, 1'b0);
    send_pixel(8'd50, 1'b0);
    settle();
    program_bins(1, bound, 0);
    send_pixel(8'd150, 1'b0);
    send_pixel(8'd10, 1'b1);
    send_pixel(8'd250, 1'b1);
    settle();

    // Random phases: new settings, then regions of random pixels
    random_pixels = 0;
    phase = 0;
    while (random_pixels < RANDOM_PIXELS) begin
      style = $urandom_range(0, 5);
      count = $urandom_range(0, ebh_pkg::MAX_EDGES);
      case (style)
        0: begin
          count = 0;
          foreach (bound[k]) bound[k] = $urandom_range(0, 255);
        end
        1: begin
          count = ebh_pkg::MAX_EDGES;
          v = $urandom_range(0, 40);
          foreach (bound[k]) begin
            bound[k] = v;
            v = (v + $urandom_range(1, 50) > 255) ? 255 : v + $urandom_range(1, 50);
          end
        end
        2: foreach (bound[k]) bound[k] = 255;
        3: foreach (bound[k]) bound[k] = 0;
        4: foreach (bound[k]) bound[k] = $urandom_range(0, 255);
        default: begin
          v = $urandom_range(0, 60);
          foreach (bound[k]) begin
            bound[k] = v;
            v = (v + $urandom_range(0, 60) > 255) ? 255 : v + $urandom_range(0, 60);
          end
        end
      endcase
      program_bins(count, bound, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 7) : 7);

      steady_src  = ($urandom_range(0, 4) == 0);
      steady_sink = ($urandom_range(0, 4) == 0);
      items       = $urandom_range(20, 60);
      region_max  = 12;
      close_phase = ($urandom_range(0, 3) != 0);
      // one phase floods the block with short regions while the result side waits
      if (phase == 2) begin
        hold_off_req = 1'b1;
        steady_src   = 1'b1;
        region_max   = 3;
        items        = 80;
        close_phase  = 1'b1;
      end

      used = int'(sb.edge_total);
      region_left = $urandom_range(1, region_max);
      for (int i = 0; i < items; i++) begin
        if (used > 0 && $urandom_range(0, 9) < 4) begin
          // hit an edge or one of its neighbors
          v = int'(sb.edge_bound[$urandom_range(0, used - 1)]) + $urandom_range(0, 2) - 1;
          v = (v < 0) ? 0 : (v > 255) ? 255 : v;
        end else begin
          v = $urandom_range(0, 255);
        end
        lst = (region_left == 1);
        if (i == items - 1) lst = close_phase;
        send_pixel(ebh_pkg::pixel_t'(v), lst);
        random_pixels++;
        region_left = lst ? $urandom_range(1, region_max) : region_left - 1;
      end
      settle();
      phase++;
    end

    $display("Run covered %0d pixels in %0d regions under %0d register settings;",
             pixels_sent, regions, settings);
    $display("%0d bin words checked; result side held off %0d time(s) for %0d cycles.",
             sb.words_checked, hold_offs, HOLD_OFF_CYCLES);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** edge_binned_histogram_unit: PASSED **");
    end else begin
      $display("** edge_binned_histogram_unit: FAILED **");
    end
    $finish;
  end
endmodule
